// ===== rtl/point_in_polygon_test_top_assert.svh =====
// Assertion macros for the point-in-polygon tester checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ppt_pkg.sv =====
// Shared types, constants and helpers for the point-in-polygon tester.
// No dependencies.
package ppt_pkg;

  localparam int MAX_VERTICES      = 64;
  localparam int COORD_BITS        = 16;
  localparam int MIN_POLY_VERTICES = 3;
  localparam int CNT_W             = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W             = $clog2(MAX_VERTICES);
  localparam int DIFF_W            = COORD_BITS + 1;
  localparam int PROD_W            = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_WALK,
    ST_DONE
  } state_e;

  // Parity token that walks the cell row.
  typedef struct packed {
    logic valid;
    logic parity;
  } token_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic wr_en;
    logic active;
  } cell_ctrl_t;

  function automatic diff_t sext_diff(coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

endpackage

// ===== rtl/ppt_req_if.sv =====
// Request channel: operation code and coordinates.
// Depends on ppt_pkg.
interface ppt_req_if import ppt_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  coord_t     coord_x;
  coord_t     coord_y;

  modport source (output valid, output op, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input op, input coord_x, input coord_y, output ready);
endinterface

// ===== rtl/ppt_res_if.sv =====
// Result channel: inside flag and degenerate flag of one test.
// No dependencies.
interface ppt_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, output inside_res, output degenerate, input ready);
  modport sink   (input valid, input inside_res, input degenerate, output ready);
endinterface

// ===== rtl/point_in_polygon_test_top.sv =====
// Top level of the point-in-polygon tester: control, vertex count and the cell row.
// Depends on ppt_pkg, ppt_req_if, ppt_res_if and ppt_cell.
//
//   channel | dir | payload                 | transaction
//   --------+-----+-------------------------+------------------------------------
//   req_i   | in  | op, coord_x, coord_y    | clear, append a vertex, test a point
//   res_o   | out | inside_res, degenerate  | one per test, none otherwise
//
// Clear and append are taken in the idle state, so req_i stays ready after them.
// A test with three or more vertices holds req_i not ready while the edge products
// are formed in every cell, then while the parity token hops one cell per cycle
// through all MAX_VERTICES cells, and then through the hand-off state.
// A test on fewer than three vertices goes straight to the hand-off state.
// Reset clears the vertex count and the control; the vertex registers hold garbage
// until written. A stalled res_o holds a finished test in the hand-off state.
module point_in_polygon_test_top import ppt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  ppt_req_if.sink   req_i,
  ppt_res_if.source res_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  coord_t           last_x_q, last_y_q;
  coord_t           pt_x_q, pt_y_q;
  logic             load_pt;
  logic             append_wr;
  logic             res_inside_q, res_inside_d;
  logic             res_deg_q, res_deg_d;
  logic             out_valid_q, out_valid_d;
  logic             out_inside_q, out_deg_q;
  logic             out_load;
  token_t           head_token;

  cell_ctrl_t ctrl  [MAX_VERTICES];
  coord_t     vx    [MAX_VERTICES];
  coord_t     vy    [MAX_VERTICES];
  token_t     token [MAX_VERTICES+1];

  assign req_i.ready = (state_q == ST_IDLE);

  // Next state, vertex count and result capture.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    load_pt      = 1'b0;
    append_wr    = 1'b0;
    res_inside_d = res_inside_q;
    res_deg_d    = res_deg_q;
    out_load     = 1'b0;
    head_token   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.op)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              // Drop the vertex when the table is full.
              if (count_q < CNT_W'(MAX_VERTICES)) begin
                append_wr = 1'b1;
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_TEST: begin
              load_pt = 1'b1;
              if (count_q < CNT_W'(MIN_POLY_VERTICES)) begin
                res_inside_d = 1'b0;
                res_deg_d    = 1'b1;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_PROD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROD: begin
        // Products settle at this edge; launch the token into cell 0 with them.
        head_token.valid  = 1'b1;
        head_token.parity = 1'b0;
        state_d           = ST_WALK;
      end
      ST_WALK: begin
        if (token[MAX_VERTICES].valid) begin
          res_inside_d = token[MAX_VERTICES].parity;
          res_deg_d    = 1'b0;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free or draining.
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_inside_q <= res_inside_d;
    res_deg_q    <= res_deg_d;
    if (load_pt) begin
      pt_x_q <= req_i.coord_x;
      pt_y_q <= req_i.coord_y;
    end
    // Track the newest vertex; it closes the polygon at cell 0.
    if (append_wr) begin
      last_x_q <= req_i.coord_x;
      last_y_q <= req_i.coord_y;
    end
    if (out_load) begin
      out_inside_q <= res_inside_q;
      out_deg_q    <= res_deg_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = out_inside_q;
  assign res_o.degenerate = out_deg_q;

  assign token[0] = head_token;

  // Row of cells: cell k holds vertex k, its edge runs from vertex k-1.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    coord_t prev_x, prev_y;

    assign ctrl[k].wr_en  = append_wr && (count_q[IDX_W-1:0] == IDX_W'(k));
    assign ctrl[k].active = (count_q > CNT_W'(k));

    if (k == 0) begin : g_first
      assign prev_x = last_x_q;
      assign prev_y = last_y_q;
    end else begin : g_rest
      assign prev_x = vx[k-1];
      assign prev_y = vy[k-1];
    end

    ppt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[k]),
      .wr_x_i   (req_i.coord_x),
      .wr_y_i   (req_i.coord_y),
      .pt_x_i   (pt_x_q),
      .pt_y_i   (pt_y_q),
      .prev_x_i (prev_x),
      .prev_y_i (prev_y),
      .token_i  (token[k]),
      .vx_o     (vx[k]),
      .vy_o     (vy[k]),
      .token_o  (token[k+1])
    );
  end

endmodule

// ===== rtl/ppt_cell.sv =====
// One cell of the vertex row: holds a vertex, tests its edge, passes the parity token.
// Depends on ppt_pkg.
module ppt_cell import ppt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  coord_t     wr_x_i,
  input  coord_t     wr_y_i,
  input  coord_t     pt_x_i,
  input  coord_t     pt_y_i,
  input  coord_t     prev_x_i,
  input  coord_t     prev_y_i,
  input  token_t     token_i,
  output coord_t     vx_o,
  output coord_t     vy_o,
  output token_t     token_o
);

  coord_t vx_q, vy_q;
  diff_t  dy, dpx, dxe, dpy;
  prod_t  lhs_d, rhs_d, lhs_q, rhs_q;
  logic   side_d, side_q, dy_neg_q;
  logic   edge_hit;
  token_t token_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  // Edge from the previous vertex (j) to this one (i).
  assign dy     = sext_diff(prev_y_i) - sext_diff(vy_q);
  assign dpx    = sext_diff(pt_x_i) - sext_diff(vx_q);
  assign dxe    = sext_diff(prev_x_i) - sext_diff(vx_q);
  assign dpy    = sext_diff(pt_y_i) - sext_diff(vy_q);
  assign lhs_d  = dpx * dy;
  assign rhs_d  = dxe * dpy;
  assign side_d = (vy_q > pt_y_i) != (prev_y_i > pt_y_i);

  always_ff @(posedge clk_i) begin
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
    side_q   <= side_d;
    dy_neg_q <= dy[DIFF_W-1];
  end

  // Flip the comparison when dy is negative.
  assign edge_hit = side_q && (dy_neg_q ? (lhs_q > rhs_q) : (lhs_q < rhs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else begin
      token_q <= token_i;
    end
  end

  assign token_o.valid  = token_q.valid;
  assign token_o.parity = token_q.parity ^ (ctrl_i.active & edge_hit);
  assign vx_o           = vx_q;
  assign vy_o           = vy_q;

endmodule

// ===== rtl/ppt_checker.sv =====
// Port-level checker for the point-in-polygon tester, bound to the top level.
// Depends on ppt_pkg and point_in_polygon_test_top_assert.svh.
`include "point_in_polygon_test_top_assert.svh"

module ppt_checker import ppt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic [1:0] req_op_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_inside_i,
  input logic       res_deg_i
);

  `PPT_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_inside_i) && $stable(res_deg_i), "stalled result changed")

  `PPT_ASSERT_IMP(a_deg_outside, res_valid_i, !(res_inside_i && res_deg_i), "degenerate result flagged inside")

  `PPT_ASSERT_NXT(a_test_blocks, req_valid_i && req_ready_i && (req_op_i == OP_TEST), !req_ready_i, "request taken during a test")

endmodule

bind point_in_polygon_test_top ppt_checker u_ppt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_op_i     (req_i.op),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_inside_i (res_o.inside_res),
  .res_deg_i    (res_o.degenerate)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for point_in_polygon_test_top: directed table, then random polygons.
// Depends on ppt_pkg, ppt_req_if, ppt_res_if and the point_in_polygon_test_top RTL.
module tb_top;
  import ppt_pkg::*;

  // Op code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam coord_t COORD_MIN = -32768;
  localparam coord_t COORD_MAX = 32767;

  // Stop the random part once this many meaningful transactions went in.
  localparam int ITEM_TARGET = 1250;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // Cycles to keep watching the result channel after the last expected verdict.
  localparam int DRAIN_CYCLES = MAX_VERTICES + 8;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } verdict_t;

  localparam verdict_t DEGENERATE_VERDICT = '{inside_res: 1'b0, degenerate: 1'b1};
  localparam verdict_t NO_VERDICT         = '{inside_res: 1'b0, degenerate: 1'b0};

  // One row of the directed table. Rows with has_verdict set carry the verdict
  // that is obvious by inspection; all other test rows go through the predictor.
  typedef struct packed {
    logic [1:0] op;
    coord_t     x;
    coord_t     y;
    logic       has_verdict;
    verdict_t   verdict;
  } stim_row_t;

  typedef enum int {
    STYLE_WIDE,
    STYLE_TIGHT,
    STYLE_EXTREME
  } coord_style_e;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_CHOKED,
    SINK_PERIODIC
  } sink_mode_e;

  localparam stim_row_t DIRECTED[25] = '{
    // Empty polygon straight out of reset.
    '{OP_TEST,   0,         0,         1'b1, DEGENERATE_VERDICT},
    // Grow a triangle at the coordinate extremes, testing at one and two vertices.
    '{OP_APPEND, COORD_MIN, COORD_MIN, 1'b0, NO_VERDICT},
    '{OP_TEST,   0,         0,         1'b1, DEGENERATE_VERDICT},
    '{OP_APPEND, COORD_MAX, COORD_MIN, 1'b0, NO_VERDICT},
    '{OP_TEST,   0,         0,         1'b1, DEGENERATE_VERDICT},
    '{OP_APPEND, 0,         COORD_MAX, 1'b0, NO_VERDICT},
    '{OP_TEST,   0,         0,         1'b0, NO_VERDICT},
    '{OP_TEST,   COORD_MIN, COORD_MAX, 1'b0, NO_VERDICT},
    '{OP_TEST,   COORD_MAX, COORD_MAX, 1'b0, NO_VERDICT},
    // Point exactly on a vertex, then on the bottom edge.
    '{OP_TEST,   COORD_MIN, COORD_MIN, 1'b0, NO_VERDICT},
    '{OP_TEST,   0,         COORD_MIN, 1'b0, NO_VERDICT},
    // Unused op code: no state change, no verdict.
    '{OP_UNUSED, 123,       -456,      1'b0, NO_VERDICT},
    '{OP_TEST,   1,         1,         1'b0, NO_VERDICT},
    // Clear drops the polygon back to degenerate.
    '{OP_CLEAR,  0,         0,         1'b0, NO_VERDICT},
    '{OP_TEST,   0,         0,         1'b1, DEGENERATE_VERDICT},
    // Axis-aligned square, probed inside, on three of its sides and outside.
    '{OP_APPEND, -100,      -100,      1'b0, NO_VERDICT},
    '{OP_APPEND, 100,       -100,      1'b0, NO_VERDICT},
    '{OP_APPEND, 100,       100,       1'b0, NO_VERDICT},
    '{OP_APPEND, -100,      100,       1'b0, NO_VERDICT},
    '{OP_TEST,   0,         0,         1'b0, NO_VERDICT},
    '{OP_TEST,   100,       0,         1'b0, NO_VERDICT},
    '{OP_TEST,   -100,      0,         1'b0, NO_VERDICT},
    '{OP_TEST,   0,         100,       1'b0, NO_VERDICT},
    '{OP_TEST,   200,       0,         1'b0, NO_VERDICT},
    '{OP_CLEAR,  0,         0,         1'b0, NO_VERDICT}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ppt_req_if req_if ();
  ppt_res_if res_if ();

  point_in_polygon_test_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Shadow copy of the polygon, updated at each accepted request transaction.
  coord_t poly_x [MAX_VERTICES];
  coord_t poly_y [MAX_VERTICES];
  int     poly_count = 0;

  // Verdicts owed by the block, oldest first.
  verdict_t pending_verdicts [$];

  int failures      = 0;
  int counted_items = 0;
  int burst_left    = 0;
  int quiet_cycles  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Edge (i, j) flips the parity when its ends straddle the horizontal line
  // through the point and the point lies strictly left of the crossing. The
  // crossing is compared exactly by cross-multiplying; a negative dy flips it.
  function automatic logic edge_toggles(coord_t xi, coord_t yi, coord_t xj, coord_t yj,
                                        coord_t px, coord_t py);
    longint dy, lhs, rhs;
    if ((yi > py) == (yj > py)) return 1'b0;
    dy  = longint'(yj) - longint'(yi);
    lhs = (longint'(px) - longint'(xi)) * dy;
    rhs = (longint'(xj) - longint'(xi)) * (longint'(py) - longint'(yi));
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic verdict_t predict_verdict(coord_t px, coord_t py);
    verdict_t v;
    int       j;
    v = NO_VERDICT;
    if (poly_count < MIN_POLY_VERTICES) return DEGENERATE_VERDICT;
    // Start with the closing edge from the last vertex back to vertex 0.
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      if (edge_toggles(poly_x[i], poly_y[i], poly_x[j], poly_y[j], px, py))
        v.inside_res = ~v.inside_res;
      j = i;
    end
    return v;
  endfunction

  // Advance the shadow polygon by one accepted transaction and queue any verdict.
  function automatic void absorb_request(logic [1:0] op, coord_t x, coord_t y,
                                         logic has_verdict, verdict_t verdict);
    case (op)
      OP_CLEAR: begin
        poly_count = 0;
      end
      OP_APPEND: begin
        // A full table silently drops the vertex.
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end
      end
      OP_TEST: begin
        pending_verdicts.push_back(has_verdict ? verdict : predict_verdict(x, y));
      end
      default: ;
    endcase
  endfunction

  // Drive one request and hold it until the block takes it. The sender works in
  // bursts; between bursts it drops valid for a random gap, sometimes none.
  task automatic send_request(logic [1:0] op, coord_t x, coord_t y,
                              logic has_verdict = 1'b0, verdict_t verdict = NO_VERDICT);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.coord_x <= x;
    req_if.coord_y <= y;
    do @(posedge clk_i); while (!req_if.ready);
    // Ignored transactions do not count toward the stimulus target.
    if (op != OP_UNUSED && !(op == OP_APPEND && poly_count >= MAX_VERTICES))
      counted_items++;
    absorb_request(op, x, y, has_verdict, verdict);
  endtask

  function automatic coord_t pick_coord(coord_style_e style);
    case (style)
      STYLE_WIDE:  return coord_t'($urandom);
      // A narrow box makes shared y values and points on edges common.
      STYLE_TIGHT: return coord_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return 0;
          3:       return -1;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Probe points: free ones, exact vertices, and mixes of vertex x and y so the
  // point sits on the line through a vertex.
  task automatic send_probe(coord_style_e style);
    coord_t px, py;
    int     a, b;
    px = pick_coord(style);
    py = pick_coord(style);
    if (poly_count > 0) begin
      a = $urandom_range(0, poly_count - 1);
      b = $urandom_range(0, poly_count - 1);
      case ($urandom_range(0, 4))
        0: begin px = poly_x[a]; py = poly_y[a]; end
        1: begin px = poly_x[a]; py = poly_y[b]; end
        2: begin py = poly_y[a]; end
        3: begin px = coord_t'($urandom); py = coord_t'($urandom); end
        default: ;
      endcase
    end
    send_request(OP_TEST, px, py);
  endtask

  // Well-formed sequence: clear, build a polygon, test it a few times.
  task automatic send_polygon_sequence();
    coord_style_e style;
    int           size, probes, pick;
    style = coord_style_e'($urandom_range(0, 2));
    pick  = $urandom_range(0, 99);
    if (pick < 8)       size = $urandom_range(0, 2);
    else if (pick < 92) size = $urandom_range(3, 12);
    else                size = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
    send_request(OP_CLEAR, pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE));
    repeat (size) begin
      if ($urandom_range(0, 24) == 0)
        send_request(OP_UNUSED, pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE));
      send_request(OP_APPEND, pick_coord(style), pick_coord(style));
    end
    probes = $urandom_range(1, 6);
    repeat (probes) send_probe(style);
  endtask

  // Noise: any op code with any coordinates, no clear first.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_request(2'($urandom_range(0, 3)), coord_t'($urandom),
                   coord_t'($urandom));
  endtask

  initial begin : stimulus
    req_if.valid   = 1'b0;
    req_if.op      = OP_CLEAR;
    req_if.coord_x = '0;
    req_if.coord_y = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r])
      send_request(DIRECTED[r].op, DIRECTED[r].x, DIRECTED[r].y,
                   DIRECTED[r].has_verdict, DIRECTED[r].verdict);

    // Mostly well-formed polygons, with some noise mixed in.
    while (counted_items < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 85) send_polygon_sequence();
      else                            send_noise();
    end

    // Release the request channel at the last accepting edge, drain the
    // verdicts, then watch for strays.
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result receiver: switch at random between stall patterns,
  // including stretches where ready never drops.
  initial begin : receiver
    sink_mode_e mode;
    int         span, step;
    res_if.ready = 1'b0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 300);
      for (step = 0; step < span; step++) begin
        @(posedge clk_i);
        case (mode)
          SINK_OPEN:     res_if.ready <= 1'b1;
          SINK_RANDOM:   res_if.ready <= 1'($urandom_range(0, 1));
          SINK_CHOKED:   res_if.ready <= ($urandom_range(0, 7) == 0);
          default:       res_if.ready <= ((step % 7) >= 3);
        endcase
      end
    end
  end

  // Compare each verdict transaction with the oldest one owed; count idle cycles.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected verdict: inside_res=%0b degenerate=%0b",
                 res_if.inside_res, res_if.degenerate);
          failures++;
        end else begin
          want = pending_verdicts.pop_front();
          if (res_if.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, actual %0b", want.inside_res,
                   res_if.inside_res);
            failures++;
          end
          if (res_if.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, actual %0b", want.degenerate,
                   res_if.degenerate);
            failures++;
          end
        end
      end

      // Watchdog: any transaction on either channel resets the count.
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
